/* hw/rtl/mapm_pkg.sv */
// Package for the multichannel audio peak meter: word types, format codes,
// register indexes and normalization constants. No dependencies.
`default_nettype none

package mapm_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int CHAN_W = 4;
	localparam int CNT_W = 5;

	typedef enum logic [2:0] {
		FMT_U8  = 3'd0,
		FMT_S8  = 3'd1,
		FMT_U16 = 3'd2,
		FMT_S16 = 3'd3,
		FMT_S32 = 3'd4
	} fmt_t;

	typedef enum logic [0:0] {
		REG_FORMAT = 1'b0,
		REG_COUNT  = 1'b1
	} reg_idx_t;

	localparam logic [2:0] FMT_RESET = FMT_S16;
	localparam logic [CNT_W-1:0] COUNT_RESET = 5'd2;

	// Full-scale divisors 2^(b-1)-1 and the split of 2^31 into quotient
	// and remainder by each of them.
	localparam longint unsigned FULL = 64'd2147483648;
	localparam longint unsigned DEN8_L = 64'd127;
	localparam longint unsigned DEN16_L = 64'd32767;
	localparam longint unsigned DEN32_L = 64'd2147483647;
	localparam logic [30:0] DEN8 = 31'(DEN8_L);
	localparam logic [30:0] DEN16 = 31'(DEN16_L);
	localparam logic [30:0] DEN32 = 31'(DEN32_L);
	localparam logic [24:0] QUO8 = 25'(FULL / DEN8_L);
	localparam logic [24:0] QUO16 = 25'(FULL / DEN16_L);
	localparam logic [24:0] QUO32 = 25'(FULL / DEN32_L);
	localparam int REM8 = int'(FULL % DEN8_L);
	localparam int REM16 = int'(FULL % DEN16_L);
	localparam int REM32 = int'(FULL % DEN32_L);

	typedef struct packed {
		logic              req_type;
		logic [CHAN_W-1:0] channel;
		logic [31:0]       sample;
	} req_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  chan_index;
		logic signed [31:0] chan_min;
		logic [31:0]        chan_max;
		logic [31:0]        chan_abs;
		logic signed [31:0] all_min;
		logic [31:0]        all_max;
		logic [31:0]        all_abs;
		logic               bad_channel;
	} rsp_word_t;

	typedef struct packed {
		logic signed [31:0] cand_min;
		logic [31:0]        cand_max;
	} norm_t;

endpackage

`default_nettype wire

/* hw/rtl/mapm_norm.sv */
// Sample decoder and Q1.31 normalizer for one raw sample.
// Depends on mapm_pkg for the format codes, constants and norm_t.
`default_nettype none

module mapm_norm (
	input  wire logic [2:0]      fmt,
	input  wire logic [31:0]     sample,
	output mapm_pkg::norm_t      cand
);

	logic [7:0]  c8;
	logic [15:0] c16;
	logic [30:0] m;
	logic [24:0] q;
	logic [3:0]  frac;
	logic [55:0] prod;

	// Counts how many multiples of den up to r do not exceed the scaled value,
	// which is the floor of m*r/den for the small remainders used here.
	function automatic logic [3:0] frac_of(logic [34:0] scaled, logic [30:0] den, int r);
		logic [3:0] cnt;
		cnt = 4'd0;
		for (int j = 1; j <= 8; j++) begin
			if (j <= r && (35'(den) * 35'(j)) <= scaled) begin
				cnt = cnt + 4'd1;
			end
		end
		return cnt;
	endfunction

	assign c8 = sample[7:0] ^ {fmt == mapm_pkg::FMT_U8, 7'b0};
	assign c16 = sample[15:0] ^ {fmt == mapm_pkg::FMT_U16, 15'b0};

	always_comb begin
		cand.cand_min = '0;
		m = '0;
		q = mapm_pkg::QUO32;
		frac = '0;
		unique case (fmt)
			mapm_pkg::FMT_U8, mapm_pkg::FMT_S8: begin
				if (c8[7]) begin
					cand.cand_min = {c8, 24'b0};
				end else begin
					m = {24'b0, c8[6:0]};
				end
				q = mapm_pkg::QUO8;
				frac = frac_of(35'({m, 3'b0}), mapm_pkg::DEN8, mapm_pkg::REM8);
			end
			mapm_pkg::FMT_U16, mapm_pkg::FMT_S16: begin
				if (c16[15]) begin
					cand.cand_min = {c16, 16'b0};
				end else begin
					m = {16'b0, c16[14:0]};
				end
				q = mapm_pkg::QUO16;
				frac = frac_of(35'({m, 1'b0}), mapm_pkg::DEN16, mapm_pkg::REM16);
			end
			default: begin
				if (sample[31]) begin
					cand.cand_min = sample;
				end else begin
					m = sample[30:0];
				end
				q = mapm_pkg::QUO32;
				frac = frac_of(35'(m), mapm_pkg::DEN32, mapm_pkg::REM32);
			end
		endcase
		prod = {25'b0, m} * {31'b0, q};
		cand.cand_max = prod[31:0] + {28'b0, frac};
	end

endmodule

`default_nettype wire

/* hw/rtl/multichannel_audio_peak_meter_top.sv */
// Top level of the multichannel audio peak meter: pipeline, config registers
// and peak stores. Depends on mapm_pkg and mapm_norm.
//
// Channel  Direction  Handshake              Word
// req      in         req_valid/req_ready    req_word (mapm_pkg::req_word_t)
// rsp      out        rsp_valid/rsp_ready    rsp_word (mapm_pkg::rsp_word_t)
// cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_value
//
// One word is taken per cycle unless rsp stalls; it passes word_s1, s2 and rsp_word_q.
// The loop that sets this rate is the store compare and update in the second stage.
// Reset puts the format at s16, the channel count at two and clears every store.
// A stalled rsp word holds the pipeline; req_ready drops only when all stages are full.
// Any configuration write also clears the stores.
`default_nettype none

module multichannel_audio_peak_meter_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire mapm_pkg::req_word_t             req_word,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output mapm_pkg::rsp_word_t                  rsp_word,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [mapm_pkg::CNT_W-1:0]      cfg_value
);

	logic [2:0]                      fmt_q;
	logic [mapm_pkg::CNT_W-1:0]      count_q;
	logic signed [31:0]              lo_q [mapm_pkg::MAX_CHANNELS];
	logic [31:0]                     hi_q [mapm_pkg::MAX_CHANNELS];
	logic signed [31:0]              glo_lo_q;
	logic [31:0]                     glo_hi_q;

	logic                            valid_s1;
	mapm_pkg::req_word_t             word_s1;
	logic                            valid_s2;
	logic                            req_type_s2;
	logic [mapm_pkg::CHAN_W-1:0]     channel_s2;
	logic                            bad_s2;
	mapm_pkg::norm_t                 norm_s2;
	logic                            rsp_valid_q;
	mapm_pkg::rsp_word_t             rsp_word_q;

	logic                            adv_out;
	logic                            adv2;
	logic                            adv1;
	logic                            move1;
	logic                            move2;
	logic                            accept;
	logic                            cfg_write;
	logic [mapm_pkg::CNT_W-1:0]      limit;
	logic                            bad_s1;
	mapm_pkg::norm_t                 norm_s1;

	logic signed [31:0]              new_lo;
	logic [31:0]                     new_hi;
	logic signed [31:0]              new_glo_lo;
	logic [31:0]                     new_glo_hi;
	mapm_pkg::rsp_word_t             rsp_next;

	function automatic logic [31:0] peak_of(logic signed [31:0] mn, logic [31:0] mx);
		logic [31:0] mag;
		mag = mn[31] ? (32'd0 - mn) : 32'd0;
		return (mx > mag) ? mx : mag;
	endfunction

	assign adv_out = !rsp_valid_q || rsp_ready;
	assign move2 = valid_s2 && adv_out;
	assign adv2 = !valid_s2 || adv_out;
	assign move1 = valid_s1 && adv2;
	assign adv1 = !valid_s1 || adv2;
	assign req_ready = adv1;
	assign accept = req_valid && adv1;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word = rsp_word_q;

	assign limit = (count_q < mapm_pkg::CNT_W'(mapm_pkg::MAX_CHANNELS)) ?
		count_q : mapm_pkg::CNT_W'(mapm_pkg::MAX_CHANNELS);
	assign bad_s1 = {1'b0, word_s1.channel} >= limit;

	mapm_norm u_norm (
		.fmt    (fmt_q),
		.sample (word_s1.sample),
		.cand   (norm_s1)
	);

	always_comb begin
		new_lo = (norm_s2.cand_min < lo_q[channel_s2]) ? norm_s2.cand_min : lo_q[channel_s2];
		new_hi = (norm_s2.cand_max > hi_q[channel_s2]) ? norm_s2.cand_max : hi_q[channel_s2];
		new_glo_lo = (new_lo < glo_lo_q) ? new_lo : glo_lo_q;
		new_glo_hi = (new_hi > glo_hi_q) ? new_hi : glo_hi_q;
		rsp_next = '0;
		rsp_next.chan_index = channel_s2;
		if (req_type_s2) begin
			rsp_next.bad_channel = 1'b0;
		end else if (bad_s2) begin
			rsp_next.bad_channel = 1'b1;
			rsp_next.all_min = glo_lo_q;
			rsp_next.all_max = glo_hi_q;
			rsp_next.all_abs = peak_of(glo_lo_q, glo_hi_q);
		end else begin
			rsp_next.chan_min = new_lo;
			rsp_next.chan_max = new_hi;
			rsp_next.chan_abs = peak_of(new_lo, new_hi);
			rsp_next.all_min = new_glo_lo;
			rsp_next.all_max = new_glo_hi;
			rsp_next.all_abs = peak_of(new_glo_lo, new_glo_hi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= mapm_pkg::FMT_RESET;
			count_q <= mapm_pkg::COUNT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mapm_pkg::REG_FORMAT: fmt_q <= cfg_value[2:0];
				mapm_pkg::REG_COUNT: count_q <= cfg_value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mapm_pkg::MAX_CHANNELS; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
			end
			glo_lo_q <= '0;
			glo_hi_q <= '0;
		end else if (cfg_write || (move2 && req_type_s2)) begin
			for (int i = 0; i < mapm_pkg::MAX_CHANNELS; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
			end
			glo_lo_q <= '0;
			glo_hi_q <= '0;
		end else if (move2 && !bad_s2) begin
			lo_q[channel_s2] <= new_lo;
			hi_q[channel_s2] <= new_hi;
			glo_lo_q <= new_glo_lo;
			glo_hi_q <= new_glo_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= req_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				rsp_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= req_word;
		end
		if (move1) begin
			req_type_s2 <= word_s1.req_type;
			channel_s2 <= word_s1.channel;
			bad_s2 <= bad_s1;
			norm_s2 <= norm_s1;
		end
		if (move2) begin
			rsp_word_q <= rsp_next;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mapm_checker.sv */
// Port-level checks on the result channel of the peak meter, with the bind
// that attaches them to the top level. Depends on mapm_pkg.
`default_nettype none

module mapm_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire mapm_pkg::rsp_word_t rsp_word
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
		else $error("Result word changed while stalled.");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.bad_channel |->
			rsp_word.chan_min == 0 && rsp_word.chan_max == 0 && rsp_word.chan_abs == 0)
		else $error("Rejected channel reported nonzero channel peaks.");

	a_global_covers: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_word.all_abs >= rsp_word.chan_abs &&
			rsp_word.all_max >= rsp_word.chan_max && rsp_word.all_min <= rsp_word.chan_min)
		else $error("Global extremes do not cover the channel extremes.");

	a_abs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_word.chan_abs >= rsp_word.chan_max &&
			rsp_word.all_max <= 32'h8000_0000)
		else $error("Peak value out of range.");

endmodule

bind multichannel_audio_peak_meter_top mapm_checker u_mapm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_word  (rsp_word)
);

`default_nettype wire
